/* hdl/pba_pkg.sv */
// shared types and constants for the power-of-two bucket allocator
package pba_pkg;

  localparam int ADDR_W  = 20;
  localparam int SIZE_W  = 32;
  localparam int CMD_W   = 2;
  localparam int STAT_W  = 3;
  localparam int LIMIT_W = 21;

  localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(1048576);
  localparam int HDR_BYTES = 8;

  // command codes
  localparam logic [CMD_W-1:0] CMD_ALLOC   = 2'd0;
  localparam logic [CMD_W-1:0] CMD_FREE    = 2'd1;
  localparam logic [CMD_W-1:0] CMD_REALLOC = 2'd2;

  // status codes
  localparam logic [STAT_W-1:0] STAT_OK        = 3'd0;
  localparam logic [STAT_W-1:0] STAT_ZERO      = 3'd1;
  localparam logic [STAT_W-1:0] STAT_TOO_LARGE = 3'd2;
  localparam logic [STAT_W-1:0] STAT_NO_MEM    = 3'd3;
  localparam logic [STAT_W-1:0] STAT_IGNORED   = 3'd4;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_DEC,
    S_CHK,
    S_ALLOC,
    S_CARVE,
    S_POP,
    S_REL,
    S_FIN
  } state_e;

  typedef struct packed {
    logic [ADDR_W-1:0] addr;
    logic [STAT_W-1:0] status;
    logic [ADDR_W-1:0] copy_from;
    logic [ADDR_W-1:0] copy_bytes;
  } result_t;

endpackage

/* hdl/pow2_bucket_allocator.sv */
// top level of the power-of-two bucket heap allocator
//
// usage: one command word (alloc, free, realloc) enters on the input channel
// when in_valid_i is high and in_stall_o is low; exactly one result word
// leaves on the output channel when out_valid_o is high and out_stall_i low.
// heap_limit is written through cfg_we_i / cfg_wdata_i while the block idles;
// the user must keep to this, the block itself does not enforce it. an empty
// free list is refilled first, one header write per carved region (page /
// region size, at most PAGE_BYTES >> MIN_REGION_LOG2 regions). words are
// handled one at a time.
// after reset the header memory is cleared, one entry per cycle, all
// 2^(HEAP_LOG2-MIN_REGION_LOG2) entries, with in_stall_o high meanwhile.
// a result waits in the output register while the receiver stalls; the next
// word is taken and worked on meanwhile and waits before its own result
module pow2_bucket_allocator #(
  parameter int HEAP_LOG2       = 20,
  parameter int PAGE_BYTES      = 4096,
  parameter int MIN_REGION_LOG2 = 5
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // configuration
  input  logic                          cfg_we_i,
  input  logic [pba_pkg::LIMIT_W-1:0]   cfg_wdata_i,
  // command channel
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [pba_pkg::CMD_W-1:0]     cmd_i,
  input  logic [pba_pkg::SIZE_W-1:0]    req_size_i,
  input  logic [pba_pkg::ADDR_W-1:0]    req_addr_i,
  // result channel
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [pba_pkg::ADDR_W-1:0]    result_addr_o,
  output logic [pba_pkg::STAT_W-1:0]    status_o,
  output logic [pba_pkg::ADDR_W-1:0]    copy_from_o,
  output logic [pba_pkg::ADDR_W-1:0]    copy_bytes_o
);

  localparam int M  = MIN_REGION_LOG2;
  localparam int SW = HEAP_LOG2 - MIN_REGION_LOG2;   // slot index width
  localparam int NB = SW + 1;                         // bucket count
  localparam int BW = $clog2(NB);
  localparam int HW = SW + 2;                         // header: alloc, link valid, payload
  // internal byte address width, room for break plus a page
  localparam int AW = ((HEAP_LOG2 > pba_pkg::ADDR_W) ? HEAP_LOG2 : pba_pkg::ADDR_W) + 2;

  localparam logic [AW-1:0] HEAP_BYTES = AW'(1) << HEAP_LOG2;
  localparam logic [AW-1:0] PAGE_SIZE  = AW'(PAGE_BYTES);
  localparam logic [AW-1:0] PAGE_MASK  = AW'(PAGE_BYTES - 1);
  localparam logic [AW-1:0] HDR_OFF    = AW'(pba_pkg::HDR_BYTES);

  pba_pkg::state_e state_q, state_d;

  // captured command word
  logic [pba_pkg::CMD_W-1:0]  cmd_q;
  logic [pba_pkg::SIZE_W-1:0] size_q;
  logic [pba_pkg::ADDR_W-1:0] addr_q;

  // allocator state
  logic [pba_pkg::LIMIT_W-1:0] heap_limit_q;
  logic [AW-1:0] break_q, break_d;
  logic [NB-1:0] head_vld_q;
  logic [SW-1:0] head_slot_q [NB];

  // work registers
  logic          pre_ok_q, pre_ok_d;
  logic          realloc_q, realloc_d;
  logic [BW-1:0] old_bkt_q, old_bkt_d;
  logic [SW-1:0] cur_slot_q, cur_slot_d;
  logic [SW:0]   end_slot_q, end_slot_d;
  logic [SW-1:0] pop_slot_q, pop_slot_d;
  logic [SW-1:0] clr_cnt_q, clr_cnt_d;
  pba_pkg::result_t res_q, res_d;

  // output register
  logic             out_valid_q;
  pba_pkg::result_t out_q;
  logic             out_load;

  // bucket list head update
  logic          head_we;
  logic [BW-1:0] head_idx;
  logic          head_v_d;
  logic [SW-1:0] head_s_d;

  // header memory port
  logic          ram_we, ram_re;
  logic [SW-1:0] ram_waddr, ram_raddr;
  logic [HW-1:0] ram_wdata, ram_rdata;

  // size class
  logic          sz_zero, sz_too_large;
  logic [BW-1:0] sz_bkt;

  // datapath helpers
  logic [AW-1:0] addr_ext, lim, start, region_sz, span, carve_end, pop_addr, cap_old;
  logic [SW-1:0] lk_slot;
  logic [SW:0]   step, next_slot;
  logic          is_alloc, hdr_ok;
  logic [BW-1:0] hdr_bkt;

  logic in_accept;

  assign in_accept  = in_valid_i && !in_stall_o;
  assign in_stall_o = (state_q != pba_pkg::S_IDLE);

  pba_size_class #(
    .HEAP_LOG2       (HEAP_LOG2),
    .MIN_REGION_LOG2 (MIN_REGION_LOG2),
    .NB              (NB),
    .BW              (BW)
  ) u_size_class (
    .clk_i       (clk_i),
    .size_i      (size_q),
    .zero_o      (sz_zero),
    .too_large_o (sz_too_large),
    .bkt_o       (sz_bkt)
  );

  pba_hdr_ram #(
    .AW (SW),
    .DW (HW)
  ) u_hdr_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // address and size arithmetic
  assign addr_ext  = AW'(addr_q);
  assign lk_slot   = addr_ext[M +: SW];
  assign lim       = (AW'(heap_limit_q) > HEAP_BYTES) ? HEAP_BYTES : AW'(heap_limit_q);
  // break padded up to the next page boundary
  assign start     = (break_q + PAGE_MASK) & ~PAGE_MASK;
  assign region_sz = (AW'(1) << M) << sz_bkt;
  // a page of small regions, or one large region
  assign span      = (region_sz < PAGE_SIZE) ? PAGE_SIZE : region_sz;
  assign carve_end = start + span;
  assign step      = (SW+1)'(1) << sz_bkt;
  assign next_slot = {1'b0, cur_slot_q} + step;
  assign pop_addr  = (AW'(pop_slot_q) << M) + HDR_OFF;
  assign cap_old   = ((AW'(1) << M) << old_bkt_q) - HDR_OFF;

  // decode of the header read for free and realloc
  assign hdr_bkt  = ram_rdata[BW-1:0];
  assign hdr_ok   = pre_ok_q && ram_rdata[HW-1] && (ram_rdata[SW-1:0] < SW'(NB));
  assign is_alloc = (cmd_q == pba_pkg::CMD_ALLOC) ||
                    ((cmd_q == pba_pkg::CMD_REALLOC) && (addr_q == '0));

  assign out_load = (state_q == pba_pkg::S_FIN) && (!out_valid_q || !out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= pba_pkg::S_CLEAR;
      heap_limit_q <= pba_pkg::LIMIT_RESET;
      break_q      <= '0;
      head_vld_q   <= '0;
      clr_cnt_q    <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q   <= state_d;
      break_q   <= break_d;
      clr_cnt_q <= clr_cnt_d;
      if (cfg_we_i) begin
        heap_limit_q <= cfg_wdata_i;
      end
      if (head_we) begin
        head_vld_q[head_idx] <= head_v_d;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      cmd_q  <= cmd_i;
      size_q <= req_size_i;
      addr_q <= req_addr_i;
    end
    if (head_we) begin
      head_slot_q[head_idx] <= head_s_d;
    end
    if (out_load) begin
      out_q <= res_q;
    end
    pre_ok_q   <= pre_ok_d;
    realloc_q  <= realloc_d;
    old_bkt_q  <= old_bkt_d;
    cur_slot_q <= cur_slot_d;
    end_slot_q <= end_slot_d;
    pop_slot_q <= pop_slot_d;
    res_q      <= res_d;
  end

  always_comb begin
    state_d    = state_q;
    break_d    = break_q;
    clr_cnt_d  = clr_cnt_q;
    pre_ok_d   = pre_ok_q;
    realloc_d  = realloc_q;
    old_bkt_d  = old_bkt_q;
    cur_slot_d = cur_slot_q;
    end_slot_d = end_slot_q;
    pop_slot_d = pop_slot_q;
    res_d      = res_q;
    head_we    = 1'b0;
    head_idx   = sz_bkt;
    head_v_d   = 1'b1;
    head_s_d   = lk_slot;
    ram_we     = 1'b0;
    ram_waddr  = lk_slot;
    ram_wdata  = '0;
    ram_re     = 1'b0;
    ram_raddr  = lk_slot;

    unique case (state_q)
      // wipe every header once after reset
      pba_pkg::S_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_cnt_q;
        clr_cnt_d = clr_cnt_q + SW'(1);
        if (clr_cnt_q == '1) begin
          state_d = pba_pkg::S_IDLE;
        end
      end

      pba_pkg::S_IDLE: begin
        res_d = '{addr: '0, status: pba_pkg::STAT_IGNORED, copy_from: '0, copy_bytes: '0};
        if (in_valid_i) begin
          state_d = pba_pkg::S_DEC;
        end
      end

      // size class settles; header of the named region is fetched
      pba_pkg::S_DEC: begin
        pre_ok_d = (addr_q[M-1:0] == M'(pba_pkg::HDR_BYTES)) &&
                   ((addr_ext - HDR_OFF) < break_q);
        ram_re   = 1'b1;
        state_d  = pba_pkg::S_CHK;
      end

      pba_pkg::S_CHK: begin
        state_d = pba_pkg::S_FIN;
        priority if (is_alloc) begin
          realloc_d = 1'b0;
          priority if (sz_zero) begin
            res_d.status = pba_pkg::STAT_ZERO;
          end else if (sz_too_large) begin
            res_d.status = pba_pkg::STAT_TOO_LARGE;
          end else begin
            state_d = pba_pkg::S_ALLOC;
          end
        end else if (cmd_q == pba_pkg::CMD_FREE) begin
          if (hdr_ok) begin
            // push the region back on its list
            ram_we       = 1'b1;
            ram_wdata    = {1'b0, head_vld_q[hdr_bkt], head_slot_q[hdr_bkt]};
            head_we      = 1'b1;
            head_idx     = hdr_bkt;
            res_d.status = pba_pkg::STAT_OK;
          end
        end else if (cmd_q == pba_pkg::CMD_REALLOC) begin
          res_d.addr = addr_q;
          priority if (!hdr_ok) begin
            res_d.status = pba_pkg::STAT_IGNORED;
          end else if (sz_zero || (!sz_too_large && (sz_bkt <= hdr_bkt))) begin
            // fits the old region
            res_d.status = pba_pkg::STAT_OK;
          end else if (sz_too_large) begin
            res_d.addr   = '0;
            res_d.status = pba_pkg::STAT_TOO_LARGE;
          end else begin
            res_d.addr = '0;
            old_bkt_d  = hdr_bkt;
            realloc_d  = 1'b1;
            state_d    = pba_pkg::S_ALLOC;
          end
        end else begin
          res_d.status = pba_pkg::STAT_IGNORED;
        end
      end

      pba_pkg::S_ALLOC: begin
        if (head_vld_q[sz_bkt]) begin
          ram_re     = 1'b1;
          ram_raddr  = head_slot_q[sz_bkt];
          pop_slot_d = head_slot_q[sz_bkt];
          state_d    = pba_pkg::S_POP;
        end else if (carve_end > lim) begin
          res_d.addr   = '0;
          res_d.status = pba_pkg::STAT_NO_MEM;
          state_d      = pba_pkg::S_FIN;
        end else begin
          break_d    = carve_end;
          cur_slot_d = start[M +: SW];
          end_slot_d = carve_end[M +: SW+1];
          state_d    = pba_pkg::S_CARVE;
        end
      end

      // one region pushed per cycle, ascending, highest ends on top
      pba_pkg::S_CARVE: begin
        ram_we     = 1'b1;
        ram_waddr  = cur_slot_q;
        ram_wdata  = {1'b0, head_vld_q[sz_bkt], head_slot_q[sz_bkt]};
        head_we    = 1'b1;
        head_s_d   = cur_slot_q;
        cur_slot_d = next_slot[SW-1:0];
        if (next_slot == end_slot_q) begin
          state_d = pba_pkg::S_ALLOC;
        end
      end

      // take the top region and mark it allocated
      pba_pkg::S_POP: begin
        head_we      = 1'b1;
        head_v_d     = ram_rdata[HW-2];
        head_s_d     = ram_rdata[SW-1:0];
        ram_we       = 1'b1;
        ram_waddr    = pop_slot_q;
        ram_wdata    = {2'b10, SW'(sz_bkt)};
        res_d.addr   = pop_addr[pba_pkg::ADDR_W-1:0];
        res_d.status = pba_pkg::STAT_OK;
        state_d      = realloc_q ? pba_pkg::S_REL : pba_pkg::S_FIN;
      end

      // realloc moved: give back the old region
      pba_pkg::S_REL: begin
        ram_we           = 1'b1;
        ram_wdata        = {1'b0, head_vld_q[old_bkt_q], head_slot_q[old_bkt_q]};
        head_we          = 1'b1;
        head_idx         = old_bkt_q;
        res_d.copy_from  = addr_q;
        res_d.copy_bytes = cap_old[pba_pkg::ADDR_W-1:0];
        state_d          = pba_pkg::S_FIN;
      end

      pba_pkg::S_FIN: begin
        if (out_load) begin
          state_d = pba_pkg::S_IDLE;
        end
      end

      default: begin
        state_d = pba_pkg::S_IDLE;
      end
    endcase
  end

  assign out_valid_o   = out_valid_q;
  assign result_addr_o = out_q.addr;
  assign status_o      = out_q.status;
  assign copy_from_o   = out_q.copy_from;
  assign copy_bytes_o  = out_q.copy_bytes;

endmodule

/* hdl/pba_hdr_ram.sv */
// region header memory, one write and one read port, registered read data
module pba_hdr_ram #(
  parameter int AW = 15,
  parameter int DW = 17
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [DW-1:0] wdata_i,
  input  logic          re_i,
  input  logic [AW-1:0] raddr_i,
  output logic [DW-1:0] rdata_o
);

  logic [DW-1:0] mem [2**AW];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

/* hdl/pba_size_class.sv */
// maps a request size to its bucket, registered
module pba_size_class #(
  parameter int HEAP_LOG2       = 20,
  parameter int MIN_REGION_LOG2 = 5,
  parameter int NB              = HEAP_LOG2 - MIN_REGION_LOG2 + 1,
  parameter int BW              = $clog2(NB)
) (
  input  logic                     clk_i,
  input  logic [pba_pkg::SIZE_W-1:0] size_i,
  output logic                     zero_o,
  output logic                     too_large_o,
  output logic [BW-1:0]            bkt_o
);

  localparam int CW = pba_pkg::SIZE_W + 1;

  // over[b]: size does not fit a region of bucket b
  logic [NB-1:0] over;

  always_comb begin
    for (int b = 0; b < NB; b++) begin
      over[b] = {1'b0, size_i} >
                ((CW'(1) << (b + MIN_REGION_LOG2)) - CW'(pba_pkg::HDR_BYTES));
    end
  end

  always_ff @(posedge clk_i) begin
    zero_o      <= (size_i == '0);
    too_large_o <= over[NB-1];
    bkt_o       <= BW'($countones(over[NB-2:0]));
  end

endmodule

/* tb/sv/testbench.sv */
`timescale 1ns / 1ps
// self-checking testbench for the power-of-two bucket allocator
module testbench;
  import pba_pkg::*;

  // block geometry, kept equal to the instance parameters below
  localparam int HEAP_LOG2       = 20;
  localparam int PAGE_BYTES      = 4096;
  localparam int MIN_REGION_LOG2 = 5;
  localparam int NUM_BUCKETS     = HEAP_LOG2 - MIN_REGION_LOG2 + 1;
  localparam int NUM_SLOTS       = 1 << (HEAP_LOG2 - MIN_REGION_LOG2);
  localparam longint unsigned HEAP_BYTES = 64'd1 << HEAP_LOG2;

  // header word encoding of the mirror heap
  localparam logic [31:0] LINK_VALID = 32'h4000_0000;
  localparam logic [31:0] ALLOC_FLAG = 32'h8000_0000;
  localparam logic [31:0] INDEX_MASK = 32'h3FFF_FFFF;

  // the command code the block does not use
  localparam logic [CMD_W-1:0] CMD_SPARE = 2'd3;

  localparam int HOLD_CYCLES = 300;
  localparam int TAIL_CYCLES = 20;
  localparam int MAX_REPORTS = 10;

  localparam result_t R_IGNORED = '{'0, STAT_IGNORED, '0, '0};
  localparam result_t R_NONE    = '0;

  logic               clk_i       = 1'b0;
  logic               rst_ni      = 1'b0;
  logic               cfg_we_i    = 1'b0;
  logic [LIMIT_W-1:0] cfg_wdata_i = '0;
  logic               in_valid_i  = 1'b0;
  logic               in_stall_o;
  logic [CMD_W-1:0]   cmd_i       = CMD_ALLOC;
  logic [SIZE_W-1:0]  req_size_i  = '0;
  logic [ADDR_W-1:0]  req_addr_i  = '0;
  logic               out_valid_o;
  logic               out_stall_i = 1'b0;
  logic [ADDR_W-1:0]  result_addr_o;
  logic [STAT_W-1:0]  status_o;
  logic [ADDR_W-1:0]  copy_from_o;
  logic [ADDR_W-1:0]  copy_bytes_o;

  pow2_bucket_allocator #(
    .HEAP_LOG2      (HEAP_LOG2),
    .PAGE_BYTES     (PAGE_BYTES),
    .MIN_REGION_LOG2(MIN_REGION_LOG2)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .cmd_i        (cmd_i),
    .req_size_i   (req_size_i),
    .req_addr_i   (req_addr_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .result_addr_o(result_addr_o),
    .status_o     (status_o),
    .copy_from_o  (copy_from_o),
    .copy_bytes_o (copy_bytes_o)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // generous cap on the whole run, the reset clearing pass included
  initial begin
    #2_000_000;
    $display("FAILURE");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // mirror of the heap: break, free-list heads and one header word per slot
  // ---------------------------------------------------------------------------
  logic [LIMIT_W-1:0] limit_mirror;
  longint unsigned    break_mirror;
  logic [31:0]        free_head [NUM_BUCKETS];
  logic [31:0]        slot_word [NUM_SLOTS];
  logic [ADDR_W-1:0]  live_addrs [$];   // data addresses currently handed out
  result_t            reply_q [$];      // replies still owed by the block, oldest first
  int                 mismatches = 0;
  int                 replies_seen = 0;

  // idling controls: the sender percentage lives in the stimulus process,
  // the receiver reads its own percentage and the hold-off request
  int                 send_idle_pct = 0;
  int                 recv_idle_pct = 0;
  logic               pressure_go = 1'b0;

  function automatic longint unsigned region_size(int b);
    return 64'd1 << (b + MIN_REGION_LOG2);
  endfunction

  // pad the break to a page, then push a page of regions (or one region
  // when it is page sized or more) so the highest address ends on top
  function automatic bit refill_bucket(int b);
    longint unsigned rsize, first, count, stop, lim, slot, i;
    rsize = region_size(b);
    first = ((break_mirror + PAGE_BYTES - 1) / PAGE_BYTES) * PAGE_BYTES;
    count = (rsize < PAGE_BYTES) ? PAGE_BYTES / rsize : 1;
    stop  = first + count * rsize;
    lim   = (limit_mirror > HEAP_BYTES) ? HEAP_BYTES : limit_mirror;
    if (stop > lim) return 1'b0;
    for (i = 0; i < count; i++) begin
      slot = (first + i * rsize) >> MIN_REGION_LOG2;
      if (slot < NUM_SLOTS) begin
        slot_word[slot] = free_head[b];
        free_head[b]    = LINK_VALID | 32'(slot);
      end
    end
    break_mirror = stop;
    return 1'b1;
  endfunction

  // smallest bucket whose region minus the header holds the size, popped
  function automatic logic [STAT_W-1:0] take_region(input logic [SIZE_W-1:0] size,
                                                    output logic [ADDR_W-1:0] got_addr);
    int b;
    longint unsigned slot;
    got_addr = '0;
    if (size == 0) return STAT_ZERO;
    b = 0;
    while (b < NUM_BUCKETS && 64'(size) > region_size(b) - HDR_BYTES) b++;
    if (b >= NUM_BUCKETS) return STAT_TOO_LARGE;
    if ((free_head[b] & LINK_VALID) == 0) begin
      if (!refill_bucket(b)) return STAT_NO_MEM;
    end
    slot = free_head[b] & INDEX_MASK;
    if (slot >= NUM_SLOTS) return STAT_NO_MEM;
    free_head[b]    = slot_word[slot];
    slot_word[slot] = ALLOC_FLAG | 32'(b);
    got_addr = ADDR_W'((slot << MIN_REGION_LOG2) + HDR_BYTES);
    live_addrs.push_back(got_addr);
    return STAT_OK;
  endfunction

  // bucket of the allocated region behind a data address, or -1
  function automatic int find_region(input logic [ADDR_W-1:0] addr,
                                     output longint unsigned slot);
    longint unsigned reg_at;
    logic [31:0] hdr;
    slot = 0;
    if (addr < HDR_BYTES) return -1;
    reg_at = addr - HDR_BYTES;
    if (reg_at % (64'd1 << MIN_REGION_LOG2) != 0 || reg_at >= break_mirror) return -1;
    slot = reg_at >> MIN_REGION_LOG2;
    if (slot >= NUM_SLOTS) return -1;
    hdr = slot_word[slot];
    if ((hdr & ALLOC_FLAG) == 0 || (hdr & INDEX_MASK) >= NUM_BUCKETS) return -1;
    return int'(hdr & INDEX_MASK);
  endfunction

  function automatic void give_back(longint unsigned slot, int b);
    logic [ADDR_W-1:0] data_addr;
    int i;
    slot_word[slot] = free_head[b];
    free_head[b]    = LINK_VALID | 32'(slot);
    data_addr = ADDR_W'((slot << MIN_REGION_LOG2) + HDR_BYTES);
    for (i = 0; i < live_addrs.size(); i++)
      if (live_addrs[i] == data_addr) begin
        live_addrs.delete(i);
        break;
      end
  endfunction

  // reply the block owes for one command word, updating the mirror heap
  function automatic result_t predict_heap_reply(logic [CMD_W-1:0] cmd,
                                                 logic [SIZE_W-1:0] size,
                                                 logic [ADDR_W-1:0] addr);
    result_t r;
    int b;
    longint unsigned slot, cap;
    logic [ADDR_W-1:0] granted;
    r = '0;
    r.status = STAT_IGNORED;
    granted = '0;
    if (cmd == CMD_ALLOC || (cmd == CMD_REALLOC && addr == 0)) begin
      r.status = take_region(size, granted);
    end else if (cmd == CMD_FREE) begin
      b = find_region(addr, slot);
      if (b >= 0) begin
        give_back(slot, b);
        r.status = STAT_OK;
      end
    end else if (cmd == CMD_REALLOC) begin
      b = find_region(addr, slot);
      if (b < 0) begin
        granted = addr;
      end else begin
        cap = region_size(b) - HDR_BYTES;
        if (64'(size) <= cap) begin
          // fits in place, never shrinks
          granted  = addr;
          r.status = STAT_OK;
        end else begin
          r.status = take_region(size, granted);
          if (r.status == STAT_OK) begin
            r.copy_from  = addr;
            r.copy_bytes = ADDR_W'(cap);
            give_back(slot, b);
          end
        end
      end
    end
    r.addr = granted;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // receiver: random stalls, plus one long hold-off that fills the block up
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin : receiver
    int hold_left;
    logic pressure_seen;
    if (pressure_go && pressure_seen !== 1'b1) begin
      pressure_seen = 1'b1;
      hold_left     = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  // ---------------------------------------------------------------------------
  // reply check: every accepted word against the oldest owed reply
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin : reply_check
    result_t got, want;
    if (rst_ni && out_valid_o === 1'b1 && out_stall_i == 1'b0) begin
      got = '{result_addr_o, status_o, copy_from_o, copy_bytes_o};
      replies_seen++;
      if (reply_q.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("reply %0d: unexpected word addr=%h status=%0d", replies_seen,
                   got.addr, got.status);
      end else begin
        want = reply_q.pop_front();
        if (got.addr !== want.addr || got.status !== want.status ||
            got.copy_from !== want.copy_from || got.copy_bytes !== want.copy_bytes) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display({"reply %0d: expected addr=%h status=%0d from=%h bytes=%0d,",
                      " got addr=%h status=%0d from=%h bytes=%0d"}, replies_seen,
                     want.addr, want.status, want.copy_from, want.copy_bytes,
                     got.addr, got.status, got.copy_from, got.copy_bytes);
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // directed words: a reply is typed in only where it is obvious
  // ---------------------------------------------------------------------------
  typedef struct packed {
    logic [CMD_W-1:0]  cmd;
    logic [SIZE_W-1:0] size;
    logic [ADDR_W-1:0] addr;
    logic              typed;
    result_t           want;
  } directed_word_t;

  localparam int DIRECTED_N = 24;

  // heap starts empty: bucket 0 carves page 0 (first grant 4072, then 4040),
  // bucket 1 carves the next page (first grant 8136)
  directed_word_t directed_tbl [DIRECTED_N] = '{
    '{CMD_ALLOC,   32'd0,          20'd0,       1'b1, '{'0, STAT_ZERO, '0, '0}},
    '{CMD_ALLOC,   32'hFFFF_FFFF,  20'd0,       1'b1, '{'0, STAT_TOO_LARGE, '0, '0}},
    '{CMD_ALLOC,   32'd1048569,    20'd0,       1'b1, '{'0, STAT_TOO_LARGE, '0, '0}},
    '{CMD_ALLOC,   32'd1,          20'd0,       1'b0, R_NONE},
    '{CMD_ALLOC,   32'd24,         20'd0,       1'b0, R_NONE},
    '{CMD_ALLOC,   32'd25,         20'd0,       1'b0, R_NONE},
    // largest bucket, but the break is already past zero
    '{CMD_ALLOC,   32'd1048568,    20'd0,       1'b1, '{'0, STAT_NO_MEM, '0, '0}},
    '{CMD_FREE,    32'd0,          20'd0,       1'b1, R_IGNORED},
    '{CMD_FREE,    32'd0,          20'hFFFFF,   1'b1, R_IGNORED},
    '{CMD_FREE,    32'd0,          20'd4073,    1'b1, R_IGNORED},
    '{CMD_FREE,    32'd0,          20'd4072,    1'b1, '{'0, STAT_OK, '0, '0}},
    // double free
    '{CMD_FREE,    32'd0,          20'd4072,    1'b1, R_IGNORED},
    '{CMD_SPARE,   32'hFFFF_FFFF,  20'hFFFFF,   1'b1, R_IGNORED},
    // realloc of null behaves as alloc
    '{CMD_REALLOC, 32'd100,        20'd0,       1'b0, R_NONE},
    // realloc of a freed region keeps the address
    '{CMD_REALLOC, 32'd10,         20'd4072,    1'b1, '{20'd4072, STAT_IGNORED, '0, '0}},
    '{CMD_REALLOC, 32'd0,          20'd4040,    1'b1, '{20'd4040, STAT_OK, '0, '0}},
    '{CMD_REALLOC, 32'd24,         20'd4040,    1'b1, '{20'd4040, STAT_OK, '0, '0}},
    // growing realloc moves and reports the copy
    '{CMD_REALLOC, 32'd200,        20'd4040,    1'b0, R_NONE},
    '{CMD_REALLOC, 32'hFFFF_FFFF,  20'd8136,    1'b1, '{'0, STAT_TOO_LARGE, '0, '0}},
    '{CMD_REALLOC, 32'd1048568,    20'd8136,    1'b1, '{'0, STAT_NO_MEM, '0, '0}},
    '{CMD_FREE,    32'd0,          20'd8136,    1'b1, '{'0, STAT_OK, '0, '0}},
    '{CMD_ALLOC,   32'd4096,       20'd0,       1'b0, R_NONE},
    '{CMD_ALLOC,   32'd65528,      20'd0,       1'b0, R_NONE},
    // slot 0 sits on a free list
    '{CMD_FREE,    32'd0,          20'd8,       1'b1, R_IGNORED}
  };

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------

  // one command word: optional idle gap, then hold it until accepted
  task automatic send_word(input logic [CMD_W-1:0] cmd, input logic [SIZE_W-1:0] size,
                           input logic [ADDR_W-1:0] addr, input logic typed,
                           input result_t want, output logic [STAT_W-1:0] st);
    result_t predicted;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    cmd_i      <= cmd;
    req_size_i <= size;
    req_addr_i <= addr;
    do @(posedge clk_i); while (in_stall_o !== 1'b0);
    predicted = predict_heap_reply(cmd, size, addr);
    reply_q.push_back(typed ? want : predicted);
    st = predicted.status;
  endtask

  // mostly small requests, some page sized, a few large, some on capacity edges
  function automatic logic [SIZE_W-1:0] pick_size();
    int roll;
    roll = $urandom_range(199);
    if (roll < 140) return SIZE_W'($urandom_range(248, 1));
    if (roll < 180) return SIZE_W'($urandom_range(4088, 249));
    if (roll < 192) return SIZE_W'($urandom_range(32760, 4089));
    if (roll < 194) return SIZE_W'($urandom_range(131064, 32761));
    return SIZE_W'((32'd1 << $urandom_range(16, MIN_REGION_LOG2)) - HDR_BYTES +
                   $urandom_range(1));
  endfunction

  // well-formed traffic on live addresses, with some noise mixed in
  task automatic random_word(output logic [CMD_W-1:0] cmd, output logic [SIZE_W-1:0] size,
                             output logic [ADDR_W-1:0] addr);
    int pick;
    pick = $urandom_range(99);
    cmd  = CMD_ALLOC;
    size = pick_size();
    addr = '0;
    // keep the live set bounded so the heap does not run dry
    if (live_addrs.size() > 40 && pick < 40) pick += 40;
    if (pick >= 40 && pick < 70 && live_addrs.size() != 0) begin
      cmd  = CMD_FREE;
      addr = live_addrs[$urandom_range(live_addrs.size() - 1)];
    end else if (pick >= 70 && pick < 85) begin
      cmd = CMD_REALLOC;
      if (live_addrs.size() != 0) addr = live_addrs[$urandom_range(live_addrs.size() - 1)];
      if ($urandom_range(9) == 0) size = '0;
    end else if (pick >= 85) begin
      case ($urandom_range(5))
        0: begin
          cmd  = CMD_FREE;
          addr = ADDR_W'($urandom);
        end
        1: begin
          // region-aligned, maybe free, maybe live, maybe past the break
          cmd  = CMD_FREE;
          addr = ADDR_W'($urandom_range(int'(break_mirror >> MIN_REGION_LOG2)) *
                         (1 << MIN_REGION_LOG2) + HDR_BYTES);
        end
        2: begin
          cmd  = CMD_REALLOC;
          addr = ADDR_W'($urandom);
          size = $urandom;
        end
        3: begin
          cmd  = CMD_SPARE;
          addr = ADDR_W'($urandom);
          size = $urandom;
        end
        4: size = $urandom;
        default: begin
          cmd  = $urandom_range(1) ? CMD_ALLOC : CMD_REALLOC;
          size = '0;
        end
      endcase
    end
  endtask

  task automatic write_limit(input logic [LIMIT_W-1:0] value);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    limit_mirror = value;
  endtask

  // drop valid and wait for every owed reply
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (reply_q.size() != 0);
  endtask

  // one random phase under a fixed limit and idling mix; only words that the
  // block acts on count toward the phase length
  task automatic run_phase(input logic [LIMIT_W-1:0] limit, input int send_pct,
                           input int recv_pct, input int words, input bit hold);
    logic [CMD_W-1:0]  cmd;
    logic [SIZE_W-1:0] size;
    logic [ADDR_W-1:0] addr;
    logic [STAT_W-1:0] st;
    int counted;
    wait_drained();
    write_limit(limit);
    send_idle_pct = send_pct;
    recv_idle_pct <= recv_pct;
    if (hold) pressure_go <= 1'b1;
    counted = 0;
    while (counted < words) begin
      random_word(cmd, size, addr);
      send_word(cmd, size, addr, 1'b0, R_NONE, st);
      if (st != STAT_IGNORED) counted++;
    end
  endtask

  // ---------------------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    logic [STAT_W-1:0] st;
    longint unsigned mid_limit;
    int i;
    limit_mirror = LIMIT_RESET;
    break_mirror = 0;
    for (i = 0; i < NUM_BUCKETS; i++) free_head[i] = '0;
    for (i = 0; i < NUM_SLOTS; i++) slot_word[i] = '0;

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    // the block clears its header memory now and stalls its input meanwhile
    write_limit(LIMIT_RESET);

    // sender idles a little, receiver a lot
    send_idle_pct = 14;
    recv_idle_pct <= 70;
    for (i = 0; i < DIRECTED_N; i++)
      send_word(directed_tbl[i].cmd, directed_tbl[i].size, directed_tbl[i].addr,
                directed_tbl[i].typed, directed_tbl[i].want, st);

    run_phase(LIMIT_RESET, 14, 70, 250, 1'b0);
    // no room to grow: only recycled regions can be granted
    run_phase('0, 14, 70, 100, 1'b0);
    // limit just past the current break, so refills hit the edge
    mid_limit = break_mirror + $urandom_range(65536);
    if (mid_limit > HEAP_BYTES) mid_limit = HEAP_BYTES;
    run_phase(LIMIT_W'(mid_limit), 70, 14, 250, 1'b0);
    // no idling at all, opened by a long receiver hold-off
    run_phase(LIMIT_RESET, 0, 0, 330, 1'b1);

    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (mismatches == 0 && reply_q.size() == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

endmodule

/* sim.f */
hdl/pba_pkg.sv
hdl/pba_hdr_ram.sv
hdl/pba_size_class.sv
hdl/pow2_bucket_allocator.sv
tb/sv/testbench.sv
